// ===== src/jdcal_pkg.sv =====
// Shared constants, types and the floor(30.6001 * e) day-offset table for the Julian Day to calendar date pipeline.
// No dependencies.
package jdcal_pkg;

  localparam int unsigned FRAC_BITS  = 32;
  localparam int unsigned DAY_W      = 23;
  localparam int unsigned Z_W        = 24;
  localparam int unsigned N1_W       = 25;
  localparam int unsigned AL_W       = 8;
  localparam int unsigned B_W        = 24;
  localparam int unsigned N2_W       = 30;
  localparam int unsigned C_W        = 15;
  localparam int unsigned BD_W       = 10;
  localparam int unsigned N3_W       = 24;
  localparam int unsigned E_W        = 6;
  localparam int unsigned MINS_W     = 11;
  localparam int unsigned YEAR_W     = 16;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DOM_W      = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned MILLIS_W   = 16;

  // register stages from the input transfer to the result strobe
  localparam int unsigned PIPE_DEPTH = 13;

  localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(64'd1 << (FRAC_BITS - 1));

  localparam logic [DAY_W-1:0] MJD_LIMIT_DAY = DAY_W'(2378496);
  localparam logic [Z_W-1:0]   MJD_OFFSET    = Z_W'(2400001);
  localparam logic [Z_W-1:0]   GREG_START    = Z_W'(2299161);

  // alpha = floor((4Z - 7468865) / 146097), reciprocal estimate plus one correction
  localparam logic [Z_W+1:0]   ALPHA_BIAS    = (Z_W+2)'(7468865);
  localparam int unsigned      ALPHA_DIV     = 146097;
  localparam int unsigned      ALPHA_SHIFT   = N1_W;
  localparam int unsigned      ALPHA_RECIP   = (1 << ALPHA_SHIFT) / ALPHA_DIV;

  localparam int unsigned      B_OFFSET      = 1524;

  // C = floor((100B - 12210) / 36525)
  localparam int unsigned      C_SCALE       = 100;
  localparam int unsigned      C_BIAS        = 12210;
  localparam int unsigned      C_DIV         = 36525;
  localparam int unsigned      C_SHIFT       = N2_W;
  localparam int unsigned      C_RECIP       = (1 << C_SHIFT) / C_DIV;

  localparam int unsigned      D_MUL         = 1461;

  // E = floor(10000 (B - D) / 306001)
  localparam int unsigned      E_SCALE       = 10000;
  localparam int unsigned      E_DIV         = 306001;
  localparam int unsigned      E_SHIFT       = N3_W;
  localparam int unsigned      E_RECIP       = (1 << E_SHIFT) / E_DIV;

  localparam int unsigned      YEAR_OFF_LATE  = 4716;
  localparam int unsigned      YEAR_OFF_EARLY = 4715;

  localparam int unsigned      MINS_PER_DAY  = 1440;
  localparam int unsigned      MS_PER_MIN    = 60000;
  localparam int unsigned      MIN_PER_HOUR  = 60;
  // floor(m / 60) == (m * 4370) >> 18 for every m below 1440
  localparam int unsigned      HOUR_SHIFT    = 18;
  localparam int unsigned      HOUR_RECIP    = 4370;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MILLIS_W-1:0] millis;
  } tod_t;

  // floor(30.6001 * e)
  function automatic logic [BD_W-1:0] jdcal_month_days(input logic [E_W-1:0] e);
    logic [BD_W-1:0] res;
    unique case (e)
      E_W'(0):  res = BD_W'(0);
      E_W'(1):  res = BD_W'(30);
      E_W'(2):  res = BD_W'(61);
      E_W'(3):  res = BD_W'(91);
      E_W'(4):  res = BD_W'(122);
      E_W'(5):  res = BD_W'(153);
      E_W'(6):  res = BD_W'(183);
      E_W'(7):  res = BD_W'(214);
      E_W'(8):  res = BD_W'(244);
      E_W'(9):  res = BD_W'(275);
      E_W'(10): res = BD_W'(306);
      E_W'(11): res = BD_W'(336);
      E_W'(12): res = BD_W'(367);
      E_W'(13): res = BD_W'(397);
      E_W'(14): res = BD_W'(428);
      E_W'(15): res = BD_W'(459);
      default:  res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== src/julian_day_to_calendar_date.sv =====
// An input transfer (start high at an edge) passes through every stage register in order before its out_valid cycle.
// Throughput: one conversion per cycle; busy is never raised since every stage advances
// each clock and the receiver cannot stall.
// The three constant divisions each take a multiply stage for the reciprocal estimate and a
// stage for the product, subtract and one-step correction.
// Reset (rst_n low, synchronous) clears the stage valid bits; data registers are not reset.
module julian_day_to_calendar_date
  import jdcal_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [DAY_W-1:0]           in_jd_day,
  input  logic [FRAC_BITS-1:0]       in_jd_fraction,
  output logic                       out_valid,
  output logic signed [YEAR_W-1:0]   out_year,
  output logic [MONTH_W-1:0]         out_month,
  output logic [DOM_W-1:0]           out_day_of_month,
  output logic [HOUR_W-1:0]          out_hour,
  output logic [MINUTE_W-1:0]        out_minute,
  output logic [MILLIS_W-1:0]        out_millis_of_minute
);

  logic                   accept;
  logic [PIPE_DEPTH-1:0]  vld_r;
  logic [PIPE_DEPTH-1:0]  vld_nxt;

  // stage 1
  logic [Z_W-1:0]         s1_z_r, s1_z_nxt;
  logic [FRAC_BITS-1:0]   s1_fr_r, s1_fr_nxt;
  // stage 2
  logic [Z_W-1:0]         s2_z_r;
  logic                   s2_g_r, s2_g_nxt;
  logic [N1_W-1:0]        s2_n1_r, s2_n1_nxt;
  logic [MINS_W-1:0]      s2_mins_r, s2_mins_nxt;
  logic [FRAC_BITS-1:0]   s2_rem_r, s2_rem_nxt;
  // stage 3
  logic [Z_W-1:0]         s3_z_r;
  logic                   s3_g_r;
  logic [N1_W-1:0]        s3_n1_r;
  logic [AL_W-1:0]        s3_q0_r, s3_q0_nxt;
  logic [MINS_W-1:0]      s3_mins_r;
  logic [HOUR_W-1:0]      s3_hour_r, s3_hour_nxt;
  logic [MILLIS_W-1:0]    s3_millis_r, s3_millis_nxt;
  // stage 4
  logic [Z_W-1:0]         s4_z_r;
  logic                   s4_g_r;
  logic [AL_W-1:0]        s4_alpha_r, s4_alpha_nxt;
  tod_t                   tod_nxt;
  tod_t                   tod_pipe_r [PIPE_DEPTH-3];
  // stages 5 to 12
  logic [B_W-1:0]         b_nxt;
  logic [B_W-1:0]         b_pipe_r [4];
  logic [N2_W-1:0]        s6_n2_r, s6_n2_nxt;
  logic [N2_W-1:0]        s7_n2_r;
  logic [C_W-1:0]         s7_q0_r, s7_q0_nxt;
  logic [C_W-1:0]         c_nxt;
  logic [C_W-1:0]         c_pipe_r [5];
  logic [BD_W-1:0]        bd_nxt;
  logic [BD_W-1:0]        bd_pipe_r [4];
  logic [N3_W-1:0]        s10_n3_r, s10_n3_nxt;
  logic [N3_W-1:0]        s11_n3_r;
  logic [E_W-1:0]         s11_q0_r, s11_q0_nxt;
  logic [E_W-1:0]         s12_e_r, s12_e_nxt;
  // output stage
  logic signed [YEAR_W-1:0] year_r, year_nxt;
  logic [MONTH_W-1:0]     month_r, month_nxt;
  logic [DOM_W-1:0]       dom_r, dom_nxt;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: Z = floor(JD + 0.5), F = frac(JD + 0.5), MJD folded in
  always_comb begin
    logic is_mjd;
    is_mjd = (in_jd_day < MJD_LIMIT_DAY) ||
             ((in_jd_day == MJD_LIMIT_DAY) && !in_jd_fraction[FRAC_BITS-1]);
    priority if (is_mjd) begin
      s1_z_nxt  = Z_W'(in_jd_day) + MJD_OFFSET;
      s1_fr_nxt = in_jd_fraction;
    end else if (in_jd_fraction[FRAC_BITS-1]) begin
      s1_z_nxt  = Z_W'(in_jd_day) + Z_W'(1);
      s1_fr_nxt = in_jd_fraction & ~FRAC_HALF;
    end else begin
      s1_z_nxt  = Z_W'(in_jd_day);
      s1_fr_nxt = in_jd_fraction | FRAC_HALF;
    end
  end

  // stage 2: alpha numerator, minutes of day
  always_comb begin
    logic [Z_W+1:0]              quad;
    logic [FRAC_BITS+MINS_W-1:0] tod;
    quad        = {s1_z_r, 2'b00};
    s2_g_nxt    = (s1_z_r >= GREG_START);
    s2_n1_nxt   = s2_g_nxt ? N1_W'(quad - ALPHA_BIAS) : '0;
    tod         = (FRAC_BITS+MINS_W)'(s1_fr_r) * (FRAC_BITS+MINS_W)'(MINS_PER_DAY);
    s2_mins_nxt = tod[FRAC_BITS+MINS_W-1:FRAC_BITS];
    s2_rem_nxt  = tod[FRAC_BITS-1:0];
  end

  // stage 3: alpha estimate, hour, milliseconds
  always_comb begin
    logic [N1_W+AL_W-1:0]        ap;
    logic [MINS_W+13-1:0]        hp;
    logic [FRAC_BITS+MILLIS_W-1:0] mp;
    ap            = (N1_W+AL_W)'(s2_n1_r) * (N1_W+AL_W)'(ALPHA_RECIP);
    s3_q0_nxt     = ap[N1_W+AL_W-1:ALPHA_SHIFT];
    hp            = (MINS_W+13)'(s2_mins_r) * (MINS_W+13)'(HOUR_RECIP);
    s3_hour_nxt   = hp[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
    mp            = (FRAC_BITS+MILLIS_W)'(s2_rem_r) * (FRAC_BITS+MILLIS_W)'(MS_PER_MIN);
    s3_millis_nxt = mp[FRAC_BITS+MILLIS_W-1:FRAC_BITS];
  end

  // stage 4: alpha correction, minute of hour
  always_comb begin
    logic [N1_W:0]     chk;
    logic [N1_W:0]     rem;
    logic [MINS_W-1:0] mm;
    chk            = (N1_W+1)'(s3_q0_r) * (N1_W+1)'(ALPHA_DIV);
    rem            = (N1_W+1)'(s3_n1_r) - chk;
    s4_alpha_nxt   = s3_q0_r + AL_W'(rem >= (N1_W+1)'(ALPHA_DIV));
    mm             = s3_mins_r - MINS_W'(s3_hour_r) * MINS_W'(MIN_PER_HOUR);
    tod_nxt.hour   = s3_hour_r;
    tod_nxt.minute = mm[MINUTE_W-1:0];
    tod_nxt.millis = s3_millis_r;
  end

  // stage 5: A and B
  always_comb begin
    logic [Z_W-1:0] a;
    if (s4_g_r) begin
      a = s4_z_r + Z_W'(1) + Z_W'(s4_alpha_r) - Z_W'(s4_alpha_r >> 2);
    end else begin
      a = s4_z_r;
    end
    b_nxt = B_W'(a) + B_W'(B_OFFSET);
  end

  // stage 6: C numerator
  always_comb begin
    logic [N2_W:0] sc;
    sc        = (N2_W+1)'(b_pipe_r[0]) * (N2_W+1)'(C_SCALE) - (N2_W+1)'(C_BIAS);
    s6_n2_nxt = sc[N2_W-1:0];
  end

  // stage 7: C estimate
  always_comb begin
    logic [N2_W+C_W-1:0] cp;
    cp        = (N2_W+C_W)'(s6_n2_r) * (N2_W+C_W)'(C_RECIP);
    s7_q0_nxt = cp[N2_W+C_W-1:C_SHIFT];
  end

  // stage 8: C correction
  always_comb begin
    logic [N2_W:0] chk;
    logic [N2_W:0] rem;
    chk   = (N2_W+1)'(s7_q0_r) * (N2_W+1)'(C_DIV);
    rem   = (N2_W+1)'(s7_n2_r) - chk;
    c_nxt = s7_q0_r + C_W'(rem >= (N2_W+1)'(C_DIV));
  end

  // stage 9: B - D
  always_comb begin
    logic [C_W+11-1:0] dp;
    logic [B_W-1:0]    diff;
    dp     = (C_W+11)'(c_pipe_r[0]) * (C_W+11)'(D_MUL);
    diff   = b_pipe_r[3] - B_W'(dp[C_W+11-1:2]);
    bd_nxt = diff[BD_W-1:0];
  end

  // stage 10: E numerator
  assign s10_n3_nxt = N3_W'(bd_pipe_r[0]) * N3_W'(E_SCALE);

  // stage 11: E estimate
  always_comb begin
    logic [N3_W+E_W-1:0] ep;
    ep         = (N3_W+E_W)'(s10_n3_r) * (N3_W+E_W)'(E_RECIP);
    s11_q0_nxt = ep[N3_W+E_W-1:E_SHIFT];
  end

  // stage 12: E correction
  always_comb begin
    logic [N3_W:0] chk;
    logic [N3_W:0] rem;
    chk        = (N3_W+1)'(s11_q0_r) * (N3_W+1)'(E_DIV);
    rem        = (N3_W+1)'(s11_n3_r) - chk;
    s12_e_nxt  = s11_q0_r + E_W'(rem >= (N3_W+1)'(E_DIV));
  end

  // stage 13: day, month, year
  always_comb begin
    logic [BD_W-1:0]   dd;
    logic [YEAR_W-1:0] cy;
    dd = bd_pipe_r[3] - jdcal_month_days(s12_e_r);
    dom_nxt = dd[DOM_W-1:0];
    if (s12_e_r < E_W'(14)) begin
      month_nxt = MONTH_W'(s12_e_r - E_W'(1));
    end else begin
      month_nxt = MONTH_W'(s12_e_r - E_W'(13));
    end
    cy = YEAR_W'(c_pipe_r[4]);
    if (month_nxt > MONTH_W'(2)) begin
      year_nxt = signed'(cy - YEAR_W'(YEAR_OFF_LATE));
    end else begin
      year_nxt = signed'(cy - YEAR_W'(YEAR_OFF_EARLY));
    end
  end

  always_ff @(posedge clk) begin
    s1_z_r      <= s1_z_nxt;
    s1_fr_r     <= s1_fr_nxt;

    s2_z_r      <= s1_z_r;
    s2_g_r      <= s2_g_nxt;
    s2_n1_r     <= s2_n1_nxt;
    s2_mins_r   <= s2_mins_nxt;
    s2_rem_r    <= s2_rem_nxt;

    s3_z_r      <= s2_z_r;
    s3_g_r      <= s2_g_r;
    s3_n1_r     <= s2_n1_r;
    s3_q0_r     <= s3_q0_nxt;
    s3_mins_r   <= s2_mins_r;
    s3_hour_r   <= s3_hour_nxt;
    s3_millis_r <= s3_millis_nxt;

    s4_z_r      <= s3_z_r;
    s4_g_r      <= s3_g_r;
    s4_alpha_r  <= s4_alpha_nxt;

    s6_n2_r     <= s6_n2_nxt;
    s7_n2_r     <= s6_n2_r;
    s7_q0_r     <= s7_q0_nxt;
    s10_n3_r    <= s10_n3_nxt;
    s11_n3_r    <= s10_n3_r;
    s11_q0_r    <= s11_q0_nxt;
    s12_e_r     <= s12_e_nxt;

    year_r      <= year_nxt;
    month_r     <= month_nxt;
    dom_r       <= dom_nxt;

    // side payload delay lines, one entry per stage
    tod_pipe_r[0] <= tod_nxt;
    for (int i = 1; i < PIPE_DEPTH - 3; i++) begin
      tod_pipe_r[i] <= tod_pipe_r[i-1];
    end
    b_pipe_r[0] <= b_nxt;
    for (int i = 1; i < 4; i++) begin
      b_pipe_r[i] <= b_pipe_r[i-1];
    end
    c_pipe_r[0] <= c_nxt;
    for (int i = 1; i < 5; i++) begin
      c_pipe_r[i] <= c_pipe_r[i-1];
    end
    bd_pipe_r[0] <= bd_nxt;
    for (int i = 1; i < 4; i++) begin
      bd_pipe_r[i] <= bd_pipe_r[i-1];
    end
  end

  assign out_valid            = vld_r[PIPE_DEPTH-1];
  assign out_year             = year_r;
  assign out_month            = month_r;
  assign out_day_of_month     = dom_r;
  assign out_hour             = tod_pipe_r[PIPE_DEPTH-4].hour;
  assign out_minute           = tod_pipe_r[PIPE_DEPTH-4].minute;
  assign out_millis_of_minute = tod_pipe_r[PIPE_DEPTH-4].millis;

  // every transfer comes out exactly once, after passing the whole valid shift register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_DEPTH out_valid)
    else $error("result strobe missing after input transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_DEPTH))
    else $error("result strobe without matching input transfer");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= MONTH_W'(1)) && (out_month <= MONTH_W'(12)) &&
                  (out_day_of_month != '0) && (out_hour <= HOUR_W'(23)) &&
                  (out_minute <= MINUTE_W'(59)) &&
                  (out_millis_of_minute <= MILLIS_W'(59999)))
    else $error("result field out of range");

endmodule

// ===== test/julian_day_to_calendar_date_tb.sv =====
// Self-checking testbench for julian_day_to_calendar_date: directed and random timestamps
// with random start gaps, results checked field by field against a built-in predictor.
// Depends on jdcal_pkg and the julian_day_to_calendar_date RTL.
module julian_day_to_calendar_date_tb;
  import jdcal_pkg::*;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DOM_W-1:0]         dom;
    logic [HOUR_W-1:0]        hour;
    logic [MINUTE_W-1:0]      minute;
    logic [MILLIS_W-1:0]      millis;
  } calendar_t;

  typedef struct {
    logic [DAY_W-1:0]     day;
    logic [FRAC_BITS-1:0] frac;
  } stamp_t;

  localparam logic [DAY_W-1:0]     DAY_MAX  = '1;
  localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [DAY_W-1:0]         in_jd_day = '0;
  logic [FRAC_BITS-1:0]     in_jd_fraction = '0;
  logic                     busy;
  logic                     out_valid;
  logic signed [YEAR_W-1:0] out_year;
  logic [MONTH_W-1:0]       out_month;
  logic [DOM_W-1:0]         out_day_of_month;
  logic [HOUR_W-1:0]        out_hour;
  logic [MINUTE_W-1:0]      out_minute;
  logic [MILLIS_W-1:0]      out_millis_of_minute;

  stamp_t    stamps_to_send[$];
  calendar_t dates_due[$];
  int        gap_left = 0;
  int        calm_left = 0;
  int        mismatches = 0;

  julian_day_to_calendar_date dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_jd_day            (in_jd_day),
    .in_jd_fraction       (in_jd_fraction),
    .out_valid            (out_valid),
    .out_year             (out_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month),
    .out_hour             (out_hour),
    .out_minute           (out_minute),
    .out_millis_of_minute (out_millis_of_minute)
  );

  always #10 clk = ~clk;

  // Meeus conversion, exact integer form
  function automatic calendar_t to_calendar(input logic [DAY_W-1:0] day,
                                            input logic [FRAC_BITS-1:0] frac);
    longint unsigned half, z, fr, jd_a, b, c, d, e, mon, mins, rem, alpha;
    longint          yr;
    calendar_t       r;
    half = 64'd1 << (FRAC_BITS - 1);
    if (day < MJD_LIMIT_DAY || (day == MJD_LIMIT_DAY && frac < half)) begin
      z  = day + MJD_OFFSET;
      fr = frac;
    end else if (frac >= half) begin
      z  = day + 1;
      fr = frac - half;
    end else begin
      z  = day;
      fr = frac + half;
    end
    if (z < GREG_START) begin
      jd_a = z;
    end else begin
      alpha = (4 * z - 7468865) / 146097;
      jd_a  = z + 1 + alpha - alpha / 4;
    end
    b   = jd_a + 1524;
    c   = (100 * b - 12210) / 36525;
    d   = (1461 * c) / 4;
    e   = (10000 * (b - d)) / 306001;
    mon = (e < 14) ? e - 1 : e - 13;
    yr  = (mon > 2) ? $signed(c) - 4716 : $signed(c) - 4715;
    mins = (fr * 1440) >> FRAC_BITS;
    rem  = fr * 1440 - (mins << FRAC_BITS);
    r.year   = yr[YEAR_W-1:0];
    r.month  = mon[MONTH_W-1:0];
    r.dom    = DOM_W'(b - d - (306001 * e) / 10000);
    r.hour   = HOUR_W'(mins / 60);
    r.minute = MINUTE_W'(mins % 60);
    r.millis = MILLIS_W'((rem * 60000) >> FRAC_BITS);
    return r;
  endfunction

  task automatic queue_stamp(input int unsigned day, input logic [FRAC_BITS-1:0] frac);
    stamp_t s;
    s.day  = DAY_W'(day);
    s.frac = frac;
    stamps_to_send.push_back(s);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: one item per transfer, random idle cycles between items, with calm bursts
  always @(posedge clk) begin : stamp_driver
    stamp_t s;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        dates_due.push_back(to_calendar(in_jd_day, in_jd_fraction));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (stamps_to_send.size() > 0) begin
          s = stamps_to_send.pop_front();
          start          <= 1'b1;
          in_jd_day      <= s.day;
          in_jd_fraction <= s.frac;
          if (calm_left > 0) begin
            gap_left = 0;
            calm_left--;
          end else begin
            gap_left = $urandom_range(0, 17);
            if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    calendar_t want;
    if (rst_n && out_valid) begin
      if (dates_due.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %0d-%0d-%0d",
                 $time, out_year, out_month, out_day_of_month);
        mismatches++;
      end else begin
        want = dates_due.pop_front();
        check_field("year", want.year, out_year);
        check_field("month", want.month, out_month);
        check_field("day_of_month", want.dom, out_day_of_month);
        check_field("hour", want.hour, out_hour);
        check_field("minute", want.minute, out_minute);
        check_field("millis_of_minute", want.millis, out_millis_of_minute);
      end
    end
  end

  initial begin : stimulus
    int unsigned day;
    int          near;
    logic [FRAC_BITS-1:0] frac;

    // field extremes
    queue_stamp(0, '0);
    queue_stamp(0, FRAC_MAX);
    queue_stamp(DAY_MAX, '0);
    queue_stamp(DAY_MAX, FRAC_MAX);
    queue_stamp(1, 32'hAAAA_AAAA);
    queue_stamp(60000, 32'h5555_5555);
    // MJD/JD boundary at 2378496.5
    queue_stamp(MJD_LIMIT_DAY, FRAC_HALF - 1);
    queue_stamp(MJD_LIMIT_DAY, FRAC_HALF);
    queue_stamp(MJD_LIMIT_DAY - 1, FRAC_MAX);
    queue_stamp(MJD_LIMIT_DAY + 1, '0);
    // day rollover at the half-day point of a JD
    queue_stamp(2451544, FRAC_HALF);
    queue_stamp(2451545, FRAC_HALF - 1);
    // leap days, including a century that is not a leap year
    queue_stamp(51544, '0);
    queue_stamp(51603, 32'hC000_0000);
    queue_stamp(2451603, FRAC_HALF);
    queue_stamp(2415078, FRAC_HALF);
    queue_stamp(2415079, FRAC_HALF);

    repeat (900) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: day = $urandom_range(MJD_LIMIT_DAY, DAY_MAX);
        4, 5, 6:    day = $urandom_range(0, MJD_LIMIT_DAY - 1);
        7, 8: begin
          case ($urandom_range(0, 5))
            0:       near = MJD_LIMIT_DAY;
            1:       near = 2451603;
            2:       near = 2415078;
            3:       near = 51603;
            4:       near = 0;
            default: near = DAY_MAX;
          endcase
          near = near + $urandom_range(0, 6) - 3;
          if (near < 0) near = 0;
          if (near > DAY_MAX) near = DAY_MAX;
          day = near;
        end
        default:    day = $urandom & DAY_MAX;
      endcase
      case ($urandom_range(0, 7))
        0:       frac = '0;
        1:       frac = FRAC_MAX;
        2:       frac = FRAC_HALF;
        3:       frac = FRAC_HALF - 1;
        default: frac = $urandom;
      endcase
      queue_stamp(day, frac);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge so the driver and checker have settled
    do @(negedge clk);
    while (stamps_to_send.size() != 0 || start || dates_due.size() != 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    if (mismatches == 0 && dates_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
